@@ rtl/jesc_pkg.sv @@
// shared types, constants and helpers for the julia escape-time pixel unit
`timescale 1ns / 1ps

package jesc_pkg;

    // fixed field widths
    localparam int IDX_W     = 9;
    localparam int COLOR_W   = 8;
    localparam int VAL_W     = 32;
    localparam int STEP_W    = 31;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int SAT_W     = PROD_W + 2;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // parameter defaults
    localparam int COLUMNS_DEF   = 512;
    localparam int ROWS_DEF      = 512;
    localparam int FRAC_BITS_DEF = 28;

    // register indexes (byte address 4*i)
    localparam logic [2:0] REG_C_REAL   = 3'd0;
    localparam logic [2:0] REG_C_IMAG   = 3'd1;
    localparam logic [2:0] REG_ORIGIN_X = 3'd2;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd3;
    localparam logic [2:0] REG_STEP_X   = 3'd4;
    localparam logic [2:0] REG_STEP_Y   = 3'd5;
    localparam logic [2:0] REG_MAX_ITER = 3'd6;

    // register reset values
    localparam logic [VAL_W-1:0]   C_REAL_RST   = 32'hF3333333;
    localparam logic [VAL_W-1:0]   C_IMAG_RST   = 32'hFD810625;
    localparam logic [VAL_W-1:0]   ORIGIN_X_RST = 32'hE0000000;
    localparam logic [VAL_W-1:0]   ORIGIN_Y_RST = 32'hE0000000;
    localparam logic [STEP_W-1:0]  STEP_X_RST   = 31'd2097152;
    localparam logic [STEP_W-1:0]  STEP_Y_RST   = 31'd2097152;
    localparam logic [COLOR_W-1:0] MAX_ITER_RST = 8'd255;

    typedef struct packed {
        logic signed [VAL_W-1:0] c_real;
        logic signed [VAL_W-1:0] c_imag;
        logic signed [VAL_W-1:0] origin_x;
        logic signed [VAL_W-1:0] origin_y;
        logic [STEP_W-1:0]       step_x;
        logic [STEP_W-1:0]       step_y;
        logic [COLOR_W-1:0]      max_iter;
    } cfg_t;

    // clamp a wide signed value into the 32-bit signed range
    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic [SAT_W-VAL_W:0] hi;
        logic signed [VAL_W-1:0] r;
        hi = v[SAT_W-1:VAL_W-1];
        if ((&hi) || !(|hi))
            r = v[VAL_W-1:0];
        else if (v[SAT_W-1])
            r = {1'b1, {(VAL_W-1){1'b0}}};
        else
            r = {1'b0, {(VAL_W-1){1'b1}}};
        return r;
    endfunction

endpackage

@@ rtl/jesc_cfg.sv @@
// apb register bank holding the escape-time settings
`timescale 1ns / 1ps

module jesc_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [jesc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [jesc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [jesc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output jesc_pkg::cfg_t                     cfg
);

    jesc_pkg::cfg_t cfg_reg;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[jesc_pkg::APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.c_real   <= jesc_pkg::C_REAL_RST;
            cfg_reg.c_imag   <= jesc_pkg::C_IMAG_RST;
            cfg_reg.origin_x <= jesc_pkg::ORIGIN_X_RST;
            cfg_reg.origin_y <= jesc_pkg::ORIGIN_Y_RST;
            cfg_reg.step_x   <= jesc_pkg::STEP_X_RST;
            cfg_reg.step_y   <= jesc_pkg::STEP_Y_RST;
            cfg_reg.max_iter <= jesc_pkg::MAX_ITER_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                jesc_pkg::REG_C_REAL:   cfg_reg.c_real   <= pwdata;
                jesc_pkg::REG_C_IMAG:   cfg_reg.c_imag   <= pwdata;
                jesc_pkg::REG_ORIGIN_X: cfg_reg.origin_x <= pwdata;
                jesc_pkg::REG_ORIGIN_Y: cfg_reg.origin_y <= pwdata;
                jesc_pkg::REG_STEP_X:   cfg_reg.step_x   <= pwdata[jesc_pkg::STEP_W-1:0];
                jesc_pkg::REG_STEP_Y:   cfg_reg.step_y   <= pwdata[jesc_pkg::STEP_W-1:0];
                jesc_pkg::REG_MAX_ITER: cfg_reg.max_iter <= pwdata[jesc_pkg::COLOR_W-1:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            jesc_pkg::REG_C_REAL:   prdata = cfg_reg.c_real;
            jesc_pkg::REG_C_IMAG:   prdata = cfg_reg.c_imag;
            jesc_pkg::REG_ORIGIN_X: prdata = cfg_reg.origin_x;
            jesc_pkg::REG_ORIGIN_Y: prdata = cfg_reg.origin_y;
            jesc_pkg::REG_STEP_X:   prdata = jesc_pkg::APB_DATA_W'(cfg_reg.step_x);
            jesc_pkg::REG_STEP_Y:   prdata = jesc_pkg::APB_DATA_W'(cfg_reg.step_y);
            jesc_pkg::REG_MAX_ITER: prdata = jesc_pkg::APB_DATA_W'(cfg_reg.max_iter);
            default:                prdata = '0;
        endcase
    end

endmodule

@@ rtl/jesc_mul.sv @@
// shared signed 32x32 multiplier with registered product
`timescale 1ns / 1ps

module jesc_mul
(
    input  logic                                   clk,
    input  logic signed [jesc_pkg::VAL_W-1:0]      op_a,
    input  logic signed [jesc_pkg::VAL_W-1:0]      op_b,
    output logic signed [jesc_pkg::PROD_W-1:0]     prod
);

    logic signed [jesc_pkg::PROD_W-1:0] prod_reg;
    logic signed [jesc_pkg::PROD_W-1:0] prod_next;

    assign prod_next = jesc_pkg::PROD_W'(op_a) * jesc_pkg::PROD_W'(op_b);
    assign prod      = prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

@@ rtl/jesc_core.sv @@
// sequencer driving the shared multiplier through one pixel's escape iterations
`timescale 1ns / 1ps

module jesc_core
#(
    parameter int COLUMNS   = jesc_pkg::COLUMNS_DEF,
    parameter int ROWS      = jesc_pkg::ROWS_DEF,
    parameter int FRAC_BITS = jesc_pkg::FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  jesc_pkg::cfg_t                    cfg,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [jesc_pkg::IDX_W-1:0]        column,
    input  logic [jesc_pkg::IDX_W-1:0]        row,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic [jesc_pkg::COLOR_W-1:0]      res_color
);

    localparam int IDX_W   = jesc_pkg::IDX_W;
    localparam int VAL_W   = jesc_pkg::VAL_W;
    localparam int PROD_W  = jesc_pkg::PROD_W;
    localparam int SAT_W   = jesc_pkg::SAT_W;
    localparam int COLOR_W = jesc_pkg::COLOR_W;
    localparam int QP_W    = 2 * IDX_W + 2;
    // floor(x / d) = (x * rcp) >> sh, exact for every 9-bit index
    localparam int COL_SH  = IDX_W + $clog2(COLUMNS);
    localparam int ROW_SH  = IDX_W + $clog2(ROWS);
    localparam int COL_RCP = ((1 << COL_SH) + COLUMNS - 1) / COLUMNS;
    localparam int ROW_RCP = ((1 << ROW_SH) + ROWS - 1) / ROWS;
    localparam int CMP_W   = (FRAC_BITS + 4 > VAL_W + 2) ? FRAC_BITS + 4 : VAL_W + 2;
    localparam logic signed [CMP_W-1:0] FOUR = $signed(CMP_W'(1) << (FRAC_BITS + 2));

    typedef enum logic [3:0] {
        S_IDLE,
        S_QUO,
        S_REM,
        S_MULX,
        S_MULY,
        S_INIT,
        S_SQ0,
        S_SQR,
        S_SQI,
        S_UPD,
        S_DONE
    } state_t;

    state_t                    state_reg, state_next;
    logic [COLOR_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]          col_reg, col_next;
    logic [IDX_W-1:0]          row_reg, row_next;
    logic [IDX_W-1:0]          col_quo_reg, col_quo_next;
    logic [IDX_W-1:0]          row_quo_reg, row_quo_next;
    logic signed [VAL_W-1:0]   zr_reg, zr_next;
    logic signed [VAL_W-1:0]   zi_reg, zi_next;
    logic signed [VAL_W-1:0]   zrs_reg, zrs_next;
    logic signed [VAL_W-1:0]   zis_reg, zis_next;
    logic [COLOR_W-1:0]        color_reg, color_next;

    logic signed [VAL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  prod_sq;
    logic signed [PROD_W-1:0]  prod_x2;
    logic [QP_W-1:0]           col_qprod, row_qprod;
    logic [IDX_W-1:0]          col_quo, row_quo;
    logic [COLOR_W-1:0]        cap;
    logic [COLOR_W-1:0]        cnt_inc;
    logic signed [CMP_W-1:0]   zsum;
    logic                      go_on;

    jesc_mul u_mul
    (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res_color = color_reg;

    // floor shifts of the product: square and doubled cross term
    assign prod_sq = prod >>> FRAC_BITS;
    assign prod_x2 = prod >>> (FRAC_BITS - 1);

    // index wrap: reciprocal quotient registered in S_QUO, remainder formed in S_REM
    assign col_qprod = QP_W'(col_reg) * QP_W'(COL_RCP);
    assign row_qprod = QP_W'(row_reg) * QP_W'(ROW_RCP);
    assign col_quo   = IDX_W'(col_qprod >> COL_SH);
    assign row_quo   = IDX_W'(row_qprod >> ROW_SH);

    assign cap     = (cfg.max_iter == '0) ? COLOR_W'(1) : cfg.max_iter;
    assign cnt_inc = count_reg + COLOR_W'(1);
    assign zsum    = CMP_W'(zrs_reg) + CMP_W'(zis_reg);
    assign go_on   = (zsum < FOUR) && (cnt_inc < cap);

    // multiplier operand selection
    always_comb
    begin
        unique case (state_reg)
            S_MULX:
            begin
                mul_a = $signed({1'b0, cfg.step_x});
                mul_b = $signed(VAL_W'(col_reg));
            end
            S_MULY:
            begin
                mul_a = $signed({1'b0, cfg.step_y});
                mul_b = $signed(VAL_W'(row_reg));
            end
            S_INIT, S_SQ0:
            begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            S_SQR:
            begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            default:
            begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        col_quo_next = col_quo_reg;
        row_quo_next = row_quo_reg;
        zr_next      = zr_reg;
        zi_next      = zi_reg;
        zrs_next     = zrs_reg;
        zis_next     = zis_reg;
        color_next   = color_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    col_next   = column;
                    row_next   = row;
                    count_next = '0;
                    state_next = S_QUO;
                end
            end
            S_QUO:
            begin
                col_quo_next = col_quo;
                row_quo_next = row_quo;
                state_next   = S_REM;
            end
            S_REM:
            begin
                col_next   = col_reg - IDX_W'(col_quo_reg * COLUMNS);
                row_next   = row_reg - IDX_W'(row_quo_reg * ROWS);
                state_next = S_MULX;
            end
            S_MULX:
                state_next = S_MULY;
            S_MULY:
            begin
                zr_next    = jesc_pkg::sat32(SAT_W'(cfg.origin_x) + SAT_W'(prod));
                state_next = S_INIT;
            end
            S_INIT:
            begin
                zi_next    = jesc_pkg::sat32(SAT_W'(cfg.origin_y) + SAT_W'(prod));
                state_next = S_SQR;
            end
            S_SQ0:
                state_next = S_SQR;
            S_SQR:
            begin
                zrs_next   = jesc_pkg::sat32(SAT_W'(prod_sq));
                state_next = S_SQI;
            end
            S_SQI:
            begin
                zis_next   = jesc_pkg::sat32(SAT_W'(prod_sq));
                state_next = S_UPD;
            end
            S_UPD:
            begin
                zi_next    = jesc_pkg::sat32(SAT_W'(prod_x2) + SAT_W'(cfg.c_imag));
                zr_next    = jesc_pkg::sat32(SAT_W'(zrs_reg) - SAT_W'(zis_reg)
                                             + SAT_W'(cfg.c_real));
                count_next = cnt_inc;
                if (go_on)
                    state_next = S_SQ0;
                else
                begin
                    color_next = count_reg;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg     <= col_next;
        row_reg     <= row_next;
        col_quo_reg <= col_quo_next;
        row_quo_reg <= row_quo_next;
        zr_reg      <= zr_next;
        zi_reg      <= zi_next;
        zrs_reg     <= zrs_next;
        zis_reg     <= zis_next;
        color_reg   <= color_next;
    end

    // iteration count stays under the cap while iterating
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UPD |-> count_reg < cap)
        else $error("iteration count reached cap inside loop");

    // index reduction leaves the pixel inside the image
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MULX |-> (col_reg < COLUMNS) && (row_reg < ROWS))
        else $error("pixel index not reduced into image");

    // a finished result is held until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && !res_ready |=> (state_reg == S_DONE) && $stable(color_reg))
        else $error("result dropped before hand-off");

    // squares are never negative
    a_square_sign: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SQI |-> !zrs_reg[VAL_W-1])
        else $error("negative real square");

endmodule

@@ rtl/julia_escape_time_pixel_unit.sv @@
// top level of the julia-set escape-time pixel unit
`timescale 1ns / 1ps

// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+------------------------------
// pixel in  | in        | in_valid/in_stall  | column[8:0], row[8:0]
// color out | out       | out_valid/out_stall| color[7:0]
// config    | in        | apb psel/penable   | paddr[4:0], pwdata/prdata[31:0]
//
// a pixel passes through the index wrap, the start-point products and n iterations
// before its result is offered, n being the iteration count (1..max_iter);
// the single shared 32x32 multiplier is used three times per iteration plus an
// update state, and the index wrap has two steps (reciprocal quotient, remainder)
// reset (rst_n, asynchronous, active low) returns settings and control registers to their defaults
// in_stall is high from acceptance until the result moves to the output register
// a stalled output holds; the next request is accepted while it waits

module julia_escape_time_pixel_unit
#(
    parameter int COLUMNS   = jesc_pkg::COLUMNS_DEF,
    parameter int ROWS      = jesc_pkg::ROWS_DEF,
    parameter int FRAC_BITS = jesc_pkg::FRAC_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // pixel request
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [jesc_pkg::IDX_W-1:0]         column,
    input  logic [jesc_pkg::IDX_W-1:0]         row,
    // color result
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [jesc_pkg::COLOR_W-1:0]       color,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [jesc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [jesc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [jesc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    jesc_pkg::cfg_t                 cfg;
    logic                           res_valid;
    logic                           res_ready;
    logic [jesc_pkg::COLOR_W-1:0]   res_color;
    logic                           out_valid_reg, out_valid_next;
    logic [jesc_pkg::COLOR_W-1:0]   color_reg, color_next;

    // settings registers
    jesc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // iteration engine
    jesc_core
    #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .FRAC_BITS (FRAC_BITS)
    )
    u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .column    (column),
        .row       (row),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_color (res_color)
    );

    // output register: holds one result, so the engine is freed while that result waits on a stall
    assign res_ready = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign color     = color_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        color_next     = color_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            color_next     = res_color;
        end
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        color_reg <= color_next;
    end

endmodule

@@ tb/julia_escape_time_pixel_unit_tb.sv @@
// self-checking testbench for the julia escape-time pixel unit against a predictor
`timescale 1ns / 1ps

module julia_escape_time_pixel_unit_tb;

    import jesc_pkg::*;

    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int NUM_COLUMNS = COLUMNS_DEF;
    localparam int NUM_ROWS    = ROWS_DEF;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    // drain time covers a pixel that runs the full cap of 255 iterations
    localparam int DRAIN_CYCLES = 1100;

    typedef struct packed {
        logic [IDX_W-1:0] column;
        logic [IDX_W-1:0] row;
    } pixel_req_t;

    // block inputs, all known from time zero
    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  in_valid = 1'b0;
    logic [IDX_W-1:0]      column   = '0;
    logic [IDX_W-1:0]      row      = '0;
    logic                  out_stall = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;

    // block outputs
    logic                  in_stall;
    logic                  out_valid;
    logic [COLOR_W-1:0]    color;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // testbench state
    pixel_req_t         pixel_requests[$];   // requests waiting for the driver
    logic [COLOR_W-1:0] expected_colors[$];  // predicted colours, oldest first
    cfg_t               shadow_cfg;          // our copy of the register file
    int                 fail_count   = 0;
    int                 colors_seen  = 0;
    logic               in_stall_q   = 1'b1; // in_stall as sampled at the last rising edge

    // sender pacing
    int                 burst_left   = 1;
    int                 gap_left     = 0;

    // receiver pacing
    int                 seg_left     = 0;
    int                 stall_pct    = 0;
    int                 holdoff_left = 0;
    logic               holdoff_done = 1'b0;

    julia_escape_time_pixel_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .column    (column),
        .row       (row),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .color     (color),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // 10 ns clock
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // clamp into the signed 32-bit range
    function automatic longint clamp32(input longint v);
        if (v > S32_MAX)
            return S32_MAX;
        if (v < S32_MIN)
            return S32_MIN;
        return v;
    endfunction

    // escape count minus one for a pixel under the current shadow settings
    function automatic logic [COLOR_W-1:0] escape_color(input logic [IDX_W-1:0] col,
                                                        input logic [IDX_W-1:0] rw);
        longint      zr;
        longint      zi;
        longint      zrs;
        longint      zis;
        longint      four;
        longint      cr;
        longint      ci;
        int unsigned cap;
        int unsigned count;
        cap   = (shadow_cfg.max_iter == 0) ? 1 : shadow_cfg.max_iter;
        four  = longint'(4) <<< FRAC;
        cr    = longint'($signed(shadow_cfg.c_real));
        ci    = longint'($signed(shadow_cfg.c_imag));
        // start point; indices wrap at the image size, sums saturate
        zr    = clamp32(longint'($signed(shadow_cfg.origin_x))
                        + longint'(col % NUM_COLUMNS) * longint'(shadow_cfg.step_x));
        zi    = clamp32(longint'($signed(shadow_cfg.origin_y))
                        + longint'(rw % NUM_ROWS) * longint'(shadow_cfg.step_y));
        zrs   = 0;
        zis   = 0;
        count = 0;
        // escape test uses the squares of the previous iteration
        while ((zrs + zis) < four && count < cap)
        begin
            zrs   = clamp32((zr * zr) >>> FRAC);
            zis   = clamp32((zi * zi) >>> FRAC);
            zi    = clamp32(((zr * zi) >>> (FRAC - 1)) + ci);
            zr    = clamp32(zrs - zis + cr);
            count = count + 1;
        end
        return COLOR_W'(count - 1);
    endfunction

    // request driver: bursts of random length, random gaps between them
    always @(negedge clk)
    begin : drive_requests
        pixel_req_t next_req;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!(in_valid && in_stall_q))
        begin
            // no request on the bus, or the last one was just taken
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pixel_requests.size() != 0)
            begin
                next_req = pixel_requests.pop_front();
                column   <= next_req.column;
                row      <= next_req.row;
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    // a quarter of the bursts run straight on, giving stretches with no idling
                    gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 40);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        // a stalled request keeps its payload untouched
    end

    // receiver: stall pattern in segments, plus one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (holdoff_left > 0)
        begin
            out_stall    <= 1'b1;
            holdoff_left <= holdoff_left - 1;
        end
        else if (!holdoff_done && colors_seen >= 350)
        begin
            // sender keeps offering while this runs, so in_stall has to hold
            holdoff_done <= 1'b1;
            holdoff_left <= 3000;
            out_stall    <= 1'b1;
        end
        else
        begin
            if (seg_left == 0)
            begin
                seg_left <= $urandom_range(20, 200);
                case ($urandom_range(3))
                    0:       stall_pct <= 0;
                    1:       stall_pct <= 15;
                    2:       stall_pct <= 50;
                    default: stall_pct <= 85;
                endcase
            end
            else
            begin
                seg_left <= seg_left - 1;
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // monitor: predict on each accepted request, check each accepted colour
    always @(posedge clk)
    begin : watch_channels
        logic [COLOR_W-1:0] want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_colors.push_back(escape_color(column, row));
            in_stall_q <= in_stall;
            if (out_valid && !out_stall)
            begin
                if (expected_colors.size() == 0)
                begin
                    $error("color: expected none, actual %0d", color);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = expected_colors.pop_front();
                    if (color !== want)
                    begin
                        $error("color: expected %0d, actual %0d", want, color);
                        fail_count = fail_count + 1;
                    end
                end
                colors_seen = colors_seen + 1;
            end
        end
    end

    // one apb transfer: setup cycle, access cycle, completes when pready is high
    task automatic apb_xfer(input logic wr, input logic [2:0] idx,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // write one register, mirror it in the shadow copy and read it back
    task automatic program_reg(input logic [2:0] idx, input logic [APB_DATA_W-1:0] val);
        logic [APB_DATA_W-1:0] stored;
        logic [APB_DATA_W-1:0] got;
        case (idx)
            REG_C_REAL:
            begin
                shadow_cfg.c_real = val;
                stored = val;
            end
            REG_C_IMAG:
            begin
                shadow_cfg.c_imag = val;
                stored = val;
            end
            REG_ORIGIN_X:
            begin
                shadow_cfg.origin_x = val;
                stored = val;
            end
            REG_ORIGIN_Y:
            begin
                shadow_cfg.origin_y = val;
                stored = val;
            end
            REG_STEP_X:
            begin
                shadow_cfg.step_x = val[STEP_W-1:0];
                stored = {1'b0, val[STEP_W-1:0]};
            end
            REG_STEP_Y:
            begin
                shadow_cfg.step_y = val[STEP_W-1:0];
                stored = {1'b0, val[STEP_W-1:0]};
            end
            default:
            begin
                shadow_cfg.max_iter = val[COLOR_W-1:0];
                stored = {{(APB_DATA_W-COLOR_W){1'b0}}, val[COLOR_W-1:0]};
            end
        endcase
        apb_xfer(1'b1, idx, val, got);
        apb_xfer(1'b0, idx, '0, got);
        if (got !== stored)
        begin
            $error("prdata: expected %h, actual %h", stored, got);
            fail_count = fail_count + 1;
        end
    endtask

    // full register set for one phase
    task automatic load_setting(input int cr, input int ci, input int ox, input int oy,
                                input int unsigned sx, input int unsigned sy,
                                input int unsigned mi);
        program_reg(REG_C_REAL,   32'(cr));
        program_reg(REG_C_IMAG,   32'(ci));
        program_reg(REG_ORIGIN_X, 32'(ox));
        program_reg(REG_ORIGIN_Y, 32'(oy));
        program_reg(REG_STEP_X,   32'(sx));
        program_reg(REG_STEP_Y,   32'(sy));
        program_reg(REG_MAX_ITER, 32'(mi));
    endtask

    task automatic queue_pixel(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] rw);
        pixel_req_t req;
        req.column = col;
        req.row    = rw;
        pixel_requests.push_back(req);
    endtask

    task automatic queue_random_pixels(input int n);
        repeat (n)
            queue_pixel(IDX_W'($urandom), IDX_W'($urandom));
    endtask

    // block idle: nothing pending, nothing on the bus, every colour back
    task automatic wait_drained();
        while (pixel_requests.size() != 0 || in_valid || expected_colors.size() != 0)
            @(posedge clk);
        repeat (16)
            @(posedge clk);
    endtask

    // test sequence
    initial
    begin : sequencer
        int          cr;
        int          ci;
        int          ox;
        int          oy;
        int unsigned sx;
        int unsigned sy;
        int unsigned mi;

        shadow_cfg.c_real   = C_REAL_RST;
        shadow_cfg.c_imag   = C_IMAG_RST;
        shadow_cfg.origin_x = ORIGIN_X_RST;
        shadow_cfg.origin_y = ORIGIN_Y_RST;
        shadow_cfg.step_x   = STEP_X_RST;
        shadow_cfg.step_y   = STEP_Y_RST;
        shadow_cfg.max_iter = MAX_ITER_RST;

        // reset held from time zero, released once
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: corners, edges, centre and alternating index bits
        queue_pixel(9'd0,   9'd0);
        queue_pixel(9'd511, 9'd511);
        queue_pixel(9'd0,   9'd511);
        queue_pixel(9'd511, 9'd0);
        queue_pixel(9'd256, 9'd256);
        queue_pixel(9'd255, 9'd256);
        queue_pixel(9'h155, 9'h0AA);
        queue_pixel(9'h0AA, 9'h155);
        queue_pixel(9'd128, 9'd300);
        queue_pixel(9'd400, 9'd200);
        wait_drained();

        // reset window with a short cap
        load_setting(-214748365, -41875931, -536870912, -536870912, 2097152, 2097152, 24);
        queue_random_pixels(300);
        wait_drained();

        // zero cap behaves like a cap of one; long hold-off lands in this phase
        load_setting(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                     $urandom, $urandom, 0);
        queue_pixel(9'd0,   9'd0);
        queue_pixel(9'd511, 9'd511);
        queue_random_pixels(150);
        wait_drained();

        // extreme registers, start point and sums saturate
        load_setting(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 255);
        queue_pixel(9'd0,   9'd0);
        queue_pixel(9'd511, 9'd511);
        queue_pixel(9'd0,   9'd511);
        queue_pixel(9'd511, 9'd0);
        queue_random_pixels(150);
        wait_drained();

        // opposite extremes with zero steps
        load_setting(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                     0, 0, 255);
        queue_random_pixels(150);
        wait_drained();

        // z stays at zero and never escapes: full cap on every pixel, so few of them
        load_setting(0, 0, 0, 0, 0, 0, 255);
        queue_random_pixels(20);
        wait_drained();

        // random windows around the interesting part of the plane
        for (int k = 0; k < 6; k++)
        begin
            cr = int'($urandom_range(32'h5000_0000)) - 32'sh2800_0000;
            ci = int'($urandom_range(32'h5000_0000)) - 32'sh2800_0000;
            ox = int'($urandom_range(32'h4000_0000)) - 32'sh3000_0000;
            oy = int'($urandom_range(32'h4000_0000)) - 32'sh3000_0000;
            sx = $urandom_range(32'h0030_0000);
            sy = $urandom_range(32'h0030_0000);
            mi = (k == 0) ? 1 : $urandom_range(2, 64);
            load_setting(cr, ci, ox, oy, sx, sy, mi);
            queue_random_pixels(200);
            wait_drained();
        end

        // watch for stray results a full pixel time longer
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fail_count == 0 && expected_colors.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial
    begin
        #(64'd200_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ julia_escape_time_pixel_unit.f @@
rtl/jesc_pkg.sv
rtl/jesc_cfg.sv
rtl/jesc_mul.sv
rtl/jesc_core.sv
rtl/julia_escape_time_pixel_unit.sv
tb/julia_escape_time_pixel_unit_tb.sv
